// ----- src/lru_pkg.sv -----
// ----------------------------------------------------------------------------
// lru_pkg: shared types and constants for the LRU page replacement block
// Register indexes, configuration field widths and their reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package lru_pkg;

	// configuration register indexes
	typedef enum logic [0:0] {
		CFG_FRAMES_IN_USE = 1'b0,
		CFG_PAGE_COUNT    = 1'b1
	} cfg_index_t;

	localparam int FIU_W      = 4;
	localparam int PCNT_W     = 9;
	localparam int CFG_DATA_W = 9;
	localparam int FRAME_W    = 3;

	localparam logic [FIU_W-1:0]  FIU_RESET  = 4'd8;
	localparam logic [PCNT_W-1:0] PCNT_RESET = 9'd256;

endpackage

`default_nettype wire

// ----- src/lru_page_replacement.sv -----
// ----------------------------------------------------------------------------
// lru_page_replacement: least-recently-used page frame replacement
// Keeps resident pages in a recency-ordered chain of cells, one per frame.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, page_number) takes one page reference
//   per transaction. Output channel (out_valid/out_ready) returns one result
//   per reference: page_ok, hit, frame_index, evicted, evicted_page.
//   Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
//   frames_in_use (index 0) and page_count (index 1); always ready. The user
//   must write it only while the block is idle; the block does not enforce this.
// Latency and throughput:
//   A result appears in the output register in the cycle after its reference
//   is accepted. One reference per cycle is sustained unless the output stalls:
//   the match and position decode are combinational ahead of the cell chain.
// Reset:
//   All cells empty, no frames filled, frames_in_use = 8, page_count = 256.
// Stall:
//   While a result waits in the output register and out_ready is low,
//   in_ready drops; the result holds until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_page_replacement #(
	parameter int FRAMES    = 8,
	parameter int PAGE_BITS = 8
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [PAGE_BITS-1:0]              page_number,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic                                   page_ok,
	output logic                                   hit,
	output logic [lru_pkg::FRAME_W-1:0]            frame_index,
	output logic                                   evicted,
	output logic [PAGE_BITS-1:0]                   evicted_page,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [0:0]                        cfg_index,
	input  wire logic [lru_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int CNT_W = $clog2(FRAMES + 1);
	localparam int LIM_W = (CNT_W > lru_pkg::FIU_W) ? CNT_W : lru_pkg::FIU_W;
	localparam int CMP_W = (PAGE_BITS > lru_pkg::PCNT_W) ? PAGE_BITS : lru_pkg::PCNT_W;
	localparam int FOUT_W = (IDX_W > lru_pkg::FRAME_W) ? IDX_W : lru_pkg::FRAME_W;
	localparam logic [LIM_W-1:0] FRAMES_L = LIM_W'(FRAMES);

	// configuration registers
	logic [lru_pkg::FIU_W-1:0]  frames_in_use_q;
	logic [lru_pkg::PCNT_W-1:0] page_count_q;
	logic [CNT_W-1:0]           filled_q;

	// cell chain signals; index 0 is the most recent
	logic                 cell_valid [FRAMES];
	logic [PAGE_BITS-1:0] cell_page  [FRAMES];
	logic [IDX_W-1:0]     cell_frame [FRAMES];
	logic                 cell_match [FRAMES];
	logic                 cell_shift [FRAMES];

	logic                 accept;
	logic                 go;
	logic                 ok;
	logic                 any_hit;
	logic                 insert;
	logic [IDX_W-1:0]     hit_pos;
	logic [IDX_W-1:0]     hit_frame;
	logic [IDX_W-1:0]     tgt;
	logic [IDX_W-1:0]     new_frame;
	logic [CNT_W-1:0]     filled_m1;
	logic [LIM_W-1:0]     fiu_ext;
	logic [LIM_W-1:0]     limit;
	logic [FOUT_W-1:0]    frame_ext;

	// output register
	logic                 out_valid_q;
	logic                 page_ok_q;
	logic                 hit_q;
	logic [lru_pkg::FRAME_W-1:0] frame_index_q;
	logic                 evicted_q;
	logic [PAGE_BITS-1:0] evicted_page_q;

	assign cfg_ready = 1'b1;
	assign in_ready  = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;

	// take configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_in_use_q <= lru_pkg::FIU_RESET;
			page_count_q    <= lru_pkg::PCNT_RESET;
		end else if (cfg_valid) begin
			unique case (lru_pkg::cfg_index_t'(cfg_index))
				lru_pkg::CFG_FRAMES_IN_USE: begin
					frames_in_use_q <= cfg_data[lru_pkg::FIU_W-1:0];
				end
				lru_pkg::CFG_PAGE_COUNT: begin
					page_count_q <= cfg_data[lru_pkg::PCNT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// range check and active frame limit
	always_comb begin
		ok      = CMP_W'(page_number) < CMP_W'(page_count_q);
		fiu_ext = LIM_W'(frames_in_use_q);
		if (fiu_ext == '0) begin
			limit = LIM_W'(1);
		end else if (fiu_ext > FRAMES_L) begin
			limit = FRAMES_L;
		end else begin
			limit = fiu_ext;
		end
	end

	// encode the matching position and its frame; at most one cell matches
	always_comb begin
		any_hit   = 1'b0;
		hit_pos   = '0;
		hit_frame = '0;
		for (int k = 0; k < FRAMES; k++) begin
			if (cell_match[k]) begin
				any_hit   = 1'b1;
				hit_pos   = hit_pos | IDX_W'(k);
				hit_frame = hit_frame | cell_frame[k];
			end
		end
	end

	// pick the deepest position that moves: hit, next empty, or the oldest
	always_comb begin
		filled_m1 = filled_q - CNT_W'(1);
		insert    = !any_hit && (LIM_W'(filled_q) < limit);
		if (any_hit) begin
			tgt = hit_pos;
		end else if (insert) begin
			tgt = filled_q[IDX_W-1:0];
		end else begin
			tgt = filled_m1[IDX_W-1:0];
		end
		if (any_hit) begin
			new_frame = hit_frame;
		end else if (insert) begin
			new_frame = filled_q[IDX_W-1:0];
		end else begin
			new_frame = cell_frame[tgt];
		end
		go = accept && ok;
	end

	// chain of cells; the referenced page enters at the top
	for (genvar g = 0; g < FRAMES; g++) begin : g_cell
		localparam logic [IDX_W-1:0] POS = IDX_W'(g);
		logic                 pv;
		logic [PAGE_BITS-1:0] pp;
		logic [IDX_W-1:0]     pf;

		if (g == 0) begin : g_top
			assign pv = 1'b1;
			assign pp = page_number;
			assign pf = new_frame;
		end else begin : g_rest
			assign pv = cell_valid[g-1];
			assign pp = cell_page[g-1];
			assign pf = cell_frame[g-1];
		end

		assign cell_shift[g] = go && (POS <= tgt);

		lru_cell #(
			.PAGE_BITS (PAGE_BITS),
			.IDX_W     (IDX_W)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.shift      (cell_shift[g]),
			.prev_valid (pv),
			.prev_page  (pp),
			.prev_frame (pf),
			.ref_page   (page_number),
			.valid      (cell_valid[g]),
			.page       (cell_page[g]),
			.frame      (cell_frame[g]),
			.match      (cell_match[g])
		);
	end

	// count filled frames
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filled_q <= '0;
		end else if (go && insert) begin
			filled_q <= filled_q + CNT_W'(1);
		end
	end

	// hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign frame_ext = FOUT_W'(new_frame);

	always_ff @(posedge clk) begin
		if (accept) begin
			page_ok_q      <= ok;
			hit_q          <= ok && any_hit;
			frame_index_q  <= ok ? frame_ext[lru_pkg::FRAME_W-1:0] : '0;
			evicted_q      <= ok && !any_hit && !insert;
			evicted_page_q <= (ok && !any_hit && !insert) ? cell_page[tgt] : '0;
		end
	end

	assign out_valid    = out_valid_q;
	assign page_ok      = page_ok_q;
	assign hit          = hit_q;
	assign frame_index  = frame_index_q;
	assign evicted      = evicted_q;
	assign evicted_page = evicted_page_q;

endmodule

`default_nettype wire

// ----- src/lru_cell.sv -----
// ----------------------------------------------------------------------------
// lru_cell: one position of the recency stack
// Holds a resident page and its frame number. Position k of the chain is
// recency rank k. On shift, the cell takes its neighbor's entry.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_cell #(
	parameter int PAGE_BITS = 8,
	parameter int IDX_W     = 3
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 shift,
	input  wire logic                 prev_valid,
	input  wire logic [PAGE_BITS-1:0] prev_page,
	input  wire logic [IDX_W-1:0]     prev_frame,
	input  wire logic [PAGE_BITS-1:0] ref_page,
	output logic                      valid,
	output logic [PAGE_BITS-1:0]      page,
	output logic [IDX_W-1:0]          frame,
	output logic                      match
);

	logic                 valid_q;
	logic [PAGE_BITS-1:0] page_q;
	logic [IDX_W-1:0]     frame_q;

	// occupancy flag moves down the chain with its entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (shift) begin
			valid_q <= prev_valid;
		end
	end

	// take the neighbor's entry
	always_ff @(posedge clk) begin
		if (shift) begin
			page_q  <= prev_page;
			frame_q <= prev_frame;
		end
	end

	// compare the referenced page against the held one
	assign match = valid_q && (page_q == ref_page);
	assign valid = valid_q;
	assign page  = page_q;
	assign frame = frame_q;

endmodule

`default_nettype wire

// ----- src/lru_chk.sv -----
// ----------------------------------------------------------------------------
// lru_chk: port-level checks for the LRU page replacement block
// Watches the result channel for consistent field combinations and held stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_chk #(
	parameter int PAGE_BITS = 8
) (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           out_valid,
	input wire logic                           out_ready,
	input wire logic                           page_ok,
	input wire logic                           hit,
	input wire logic [lru_pkg::FRAME_W-1:0]    frame_index,
	input wire logic                           evicted,
	input wire logic [PAGE_BITS-1:0]           evicted_page
);

	// a rejected page reports nothing else
	a_reject_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !page_ok |-> !hit && !evicted && frame_index == '0
			&& evicted_page == '0)
		else $error("rejected page with nonzero result fields");

	// a hit never evicts
	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit |-> !evicted)
		else $error("hit and eviction in one result");

	// evicted page is zero unless a page was replaced
	a_evict_page: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !evicted |-> evicted_page == '0)
		else $error("evicted page set without eviction");

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(page_ok) && $stable(hit)
			&& $stable(frame_index) && $stable(evicted) && $stable(evicted_page))
		else $error("result changed while stalled");

endmodule

bind lru_page_replacement lru_chk #(.PAGE_BITS(PAGE_BITS)) u_lru_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.page_ok      (page_ok),
	.hit          (hit),
	.frame_index  (frame_index),
	.evicted      (evicted),
	.evicted_page (evicted_page)
);

`default_nettype wire

// ----- tb/lru_page_replacement_tb.sv -----
// ----------------------------------------------------------------------------
// lru_page_replacement_tb: self-checking bench for the LRU page replacement
// Drives page references through the input channel and compares every result
// against a behavioral LRU frame table kept in the bench. Directed cases hit
// frame-limit and page-count extremes. Random phases then mix working-set
// traffic with noise under varied limits, with random stalls on both sides.
// ----------------------------------------------------------------------------
module lru_page_replacement_tb;

	localparam int FRAMES     = 8;
	localparam int PAGE_BITS  = 8;
	localparam int IDLE_LIMIT = 2000;
	localparam int MAX_REPORT = 10;

	typedef struct packed {
		logic                        page_ok;
		logic                        hit;
		logic [lru_pkg::FRAME_W-1:0] frame_index;
		logic                        evicted;
		logic [PAGE_BITS-1:0]        evicted_page;
	} lookup_result_t;

	logic                             clk;
	logic                             arst_n       = 1'b0;
	logic                             in_valid     = 1'b0;
	logic                             in_ready;
	logic [PAGE_BITS-1:0]             page_number  = '0;
	logic                             out_valid;
	logic                             out_ready    = 1'b1;
	logic                             page_ok;
	logic                             hit;
	logic [lru_pkg::FRAME_W-1:0]      frame_index;
	logic                             evicted;
	logic [PAGE_BITS-1:0]             evicted_page;
	logic                             cfg_valid    = 1'b0;
	logic                             cfg_ready;
	logic [0:0]                       cfg_index    = lru_pkg::CFG_FRAMES_IN_USE;
	logic [lru_pkg::CFG_DATA_W-1:0]   cfg_data     = '0;

	// frame table mirror
	logic [PAGE_BITS-1:0]             res_page [FRAMES];
	bit                               res_valid [FRAMES];
	int                               age_rank [FRAMES];
	int                               n_filled;
	logic [lru_pkg::FIU_W-1:0]        lim_frames;
	logic [lru_pkg::PCNT_W-1:0]       lim_pages;

	lookup_result_t          expected_lookups [$];
	bit                      quiet = 1'b0;
	int                      mismatches   = 0;
	int                      n_checked    = 0;
	int                      n_refs       = 0;
	int                      n_hits       = 0;
	int                      n_evicts     = 0;
	int                      n_rejects    = 0;
	int                      n_settings   = 0;
	int                      stall_cycles = 0;

	lru_page_replacement #(
		.FRAMES    (FRAMES),
		.PAGE_BITS (PAGE_BITS)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.page_number  (page_number),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.page_ok      (page_ok),
		.hit          (hit),
		.frame_index  (frame_index),
		.evicted      (evicted),
		.evicted_page (evicted_page),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Move frame f to most recent; younger valid frames age by one
	function automatic void promote_frame(int f, int old_rank);
		for (int i = 0; i < FRAMES; i++) begin
			if (res_valid[i] && i != f && age_rank[i] < old_rank)
				age_rank[i]++;
		end
		age_rank[f] = 0;
	endfunction

	// Apply one reference to the frame table and return its result
	function automatic lookup_result_t predict_lookup(logic [PAGE_BITS-1:0] pg);
		lookup_result_t r;
		int limit;
		int f;
		int best;
		bit found;
		bit any;
		r     = '0;
		f     = 0;
		best  = 0;
		found = 1'b0;
		any   = 1'b0;
		if ({1'b0, pg} >= lim_pages) begin
			n_rejects++;
			return r;
		end
		r.page_ok = 1'b1;
		limit = lim_frames;
		if (limit < 1)
			limit = 1;
		if (limit > FRAMES)
			limit = FRAMES;
		for (int i = 0; i < FRAMES; i++) begin
			if (!found && res_valid[i] && res_page[i] == pg) begin
				f     = i;
				found = 1'b1;
			end
		end
		if (found) begin
			promote_frame(f, age_rank[f]);
			r.hit = 1'b1;
			n_hits++;
		end else if (n_filled < limit) begin
			f            = n_filled;
			res_valid[f] = 1'b1;
			res_page[f]  = pg;
			age_rank[f]  = n_filled;
			n_filled++;
			promote_frame(f, age_rank[f]);
		end else begin
			// evict the oldest page among all filled frames
			for (int i = 0; i < FRAMES; i++) begin
				if (res_valid[i] && (!any || age_rank[i] > best)) begin
					best = age_rank[i];
					f    = i;
					any  = 1'b1;
				end
			end
			r.evicted      = 1'b1;
			r.evicted_page = res_page[f];
			res_page[f]    = pg;
			promote_frame(f, age_rank[f]);
			n_evicts++;
		end
		r.frame_index = f[lru_pkg::FRAME_W-1:0];
		return r;
	endfunction

	// Send one page reference; valid stays high after acceptance
	task automatic issue_reference(logic [PAGE_BITS-1:0] pg);
		if (!quiet) begin
			while ($urandom_range(0, 99) < 13) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid    <= 1'b1;
		page_number <= pg;
		do @(posedge clk); while (!in_ready);
		expected_lookups.push_back(predict_lookup(pg));
		n_refs++;
	endtask

	// Hold off input until every expected result has been taken
	task automatic settle_results();
		in_valid <= 1'b0;
		while (expected_lookups.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// Write both limit registers back to back; block must be idle
	task automatic set_limits(logic [lru_pkg::CFG_DATA_W-1:0] fiu_data,
			logic [lru_pkg::CFG_DATA_W-1:0] pcnt_data);
		settle_results();
		cfg_valid <= 1'b1;
		cfg_index <= lru_pkg::CFG_FRAMES_IN_USE;
		cfg_data  <= fiu_data;
		do @(posedge clk); while (!cfg_ready);
		lim_frames = fiu_data[lru_pkg::FIU_W-1:0];
		cfg_index <= lru_pkg::CFG_PAGE_COUNT;
		cfg_data  <= pcnt_data;
		do @(posedge clk); while (!cfg_ready);
		lim_pages = pcnt_data[lru_pkg::PCNT_W-1:0];
		cfg_valid <= 1'b0;
		n_settings++;
	endtask

	// A zero frame limit behaves as a single frame
	task automatic test_zero_frame_limit();
		set_limits(9'd0, 9'd256);
		issue_reference(8'd5);
		issue_reference(8'd6);
		issue_reference(8'd6);
	endtask

	// Saturated limit: fill all frames, then force evictions
	task automatic test_fill_and_evict();
		set_limits(9'h1EF, 9'd511);
		issue_reference(8'd0);
		issue_reference(8'd255);
		issue_reference(8'd0);
		for (int p = 10; p < 16; p++)
			issue_reference(p[PAGE_BITS-1:0]);
		issue_reference(8'd128);
		issue_reference(8'd255);
	endtask

	// Zero page count rejects all; a count of one admits only page zero
	task automatic test_page_rejection();
		set_limits(9'h1F0, 9'd0);
		issue_reference(8'd0);
		issue_reference(8'd255);
		set_limits(9'd8, 9'd1);
		issue_reference(8'd0);
		issue_reference(8'd1);
	endtask

	// Limit below the filled count: hits anywhere, evict among all filled
	task automatic test_lowered_limit();
		set_limits(9'd2, 9'd256);
		issue_reference(8'd200);
		issue_reference(8'd0);
		issue_reference(8'd255);
		issue_reference(8'd201);
	endtask

	// Working-set traffic with noise under a fresh random setting per phase
	task automatic test_random_traffic(int phases, int per_phase);
		logic [lru_pkg::CFG_DATA_W-1:0] fiu_data;
		logic [lru_pkg::CFG_DATA_W-1:0] pcnt_data;
		int eff;
		int span;
		int base;
		logic [PAGE_BITS-1:0] pg;
		for (int ph = 0; ph < phases; ph++) begin
			fiu_data = {5'($urandom_range(0, 31)), 4'($urandom_range(0, 15))};
			case ($urandom_range(0, 9))
				0:       pcnt_data = 9'd0;
				1:       pcnt_data = 9'd511;
				2, 3:    pcnt_data = 9'($urandom_range(1, 255));
				4, 5:    pcnt_data = 9'($urandom_range(200, 300));
				default: pcnt_data = 9'd256;
			endcase
			set_limits(fiu_data, pcnt_data);
			eff = (lim_frames == 0) ? 1 : ((lim_frames > FRAMES) ? FRAMES : lim_frames);
			// keep the working set mostly below the page count
			if (pcnt_data > 0 && pcnt_data < 256)
				base = $urandom_range(0, pcnt_data);
			else
				base = $urandom_range(0, 255);
			quiet = (ph == 2);
			for (int k = 0; k < per_phase; k++) begin
				if ($urandom_range(0, 31) == 0)
					base = $urandom_range(0, 255);
				span = eff + $urandom_range(0, 3);
				if ($urandom_range(0, 7) == 0)
					pg = 8'($urandom_range(0, 255));
				else
					pg = 8'(base + $urandom_range(0, span));
				issue_reference(pg);
				// drain the pipe once mid-phase
				if (ph == 6 && k == per_phase / 2)
					settle_results();
			end
			quiet = 1'b0;
		end
	endtask

	// Output side stalls at random outside the quiet stretch
	always @(posedge clk)
		out_ready <= quiet || ($urandom_range(0, 99) >= 13);

	// Compare each result with the oldest expectation
	always @(posedge clk) begin
		lookup_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_lookups.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORT)
					$display({"unexpected result: page_ok=%0d hit=%0d frame=%0d",
						" evicted=%0d page=%0d"},
						page_ok, hit, frame_index, evicted, evicted_page);
			end else begin
				want = expected_lookups.pop_front();
				n_checked++;
				if (page_ok !== want.page_ok || hit !== want.hit ||
						frame_index !== want.frame_index || evicted !== want.evicted ||
						evicted_page !== want.evicted_page) begin
					mismatches++;
					if (mismatches <= MAX_REPORT)
						$display({"mismatch ok/hit/frame/ev/evpage: ",
							"expected %0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d"},
							want.page_ok, want.hit, want.frame_index, want.evicted,
							want.evicted_page, page_ok, hit, frame_index, evicted,
							evicted_page);
				end
			end
		end
	end

	// End the run if no transaction moves for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
			$display("FAILURE");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		for (int i = 0; i < FRAMES; i++) begin
			res_page[i]  = '0;
			res_valid[i] = 1'b0;
			age_rank[i]  = 0;
		end
		n_filled   = 0;
		lim_frames = lru_pkg::FIU_RESET;
		lim_pages  = lru_pkg::PCNT_RESET;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_zero_frame_limit();
		test_fill_and_evict();
		test_page_rejection();
		test_lowered_limit();
		test_random_traffic(10, 100);
		settle_results();

		$display({"Covered %0d references: %0d hits, %0d evictions, %0d rejected,",
			" %0d limit settings."},
			n_refs, n_hits, n_evicts, n_rejects, n_settings);
		$display("Checked %0d results, %0d mismatches.", n_checked, mismatches);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
